// ===== hw/rtl/double_ended_queue_unit_defines.svh =====
// assertion macros shared by the deque checker
// expects signals named clk and rst in the scope of each use
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define DEQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed: same-cycle implication");

// next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed: next-cycle implication");

`endif

// ===== hw/rtl/deq_pkg.sv =====
// deque package: field widths, operation and status codes, parameter defaults
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_REAR   = 3'd0,
    FN_PUSH_FRONT  = 3'd1,
    FN_POP_REAR    = 3'd2,
    FN_POP_FRONT   = 3'd3,
    FN_PEEK_REAR   = 3'd4,
    FN_PEEK_FRONT  = 3'd5,
    FN_QUERY_EMPTY = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/deq_in_if.sv =====
// request channel of the deque: operation code and word to push
// depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface deq_in_if;
  logic                               valid;
  logic                               ready;
  logic [deq_pkg::FUNC_W-1:0]         func;
  logic signed [deq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/deq_out_if.sv =====
// result channel of the deque: data word, status and empty flag
// depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface deq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [deq_pkg::DATA_W-1:0]  data;
  logic [deq_pkg::STATUS_W-1:0]       status;
  logic                               is_empty;

  modport source (output valid, output data, output status, output is_empty, input ready);
  modport sink   (input valid, input data, input status, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/deq_ram.sv =====
// entry store of the deque: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_WIDTH-1:0]    wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_WIDTH-1:0]    rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue_unit.sv =====
// results: push, emptiness query and any refused operation give their result in the cycle after acceptance;
//   pop and peek pass through the registered ram read, then the output register
// throughput: one word per cycle for pushes and queries while rsp.ready stays high; none during a pop/peek read
// reset: synchronous; clears indices, count, state and output valid;
//   the entry store is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  deq_in_if.sink   cmd,
  deq_out_if.source rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // common width for moving words between the ports and the store
  localparam int EXT_W = (DATA_WIDTH > deq_pkg::DATA_W) ? DATA_WIDTH : deq_pkg::DATA_W;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  // one-hot sequencer: idle, or waiting on the ram read of a pop/peek
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state;

  // live entries sit at rear, rear+1, ..., front-1
  logic [IDX_W-1:0] front, front_next;
  logic [IDX_W-1:0] rear, rear_next;
  logic [CNT_W-1:0] count, count_next;

  // output register
  logic                              out_valid, out_valid_next;
  logic signed [deq_pkg::DATA_W-1:0] out_data;
  deq_pkg::status_t                  out_status;
  logic                              out_empty;

  // empty flag held while the read is in flight
  logic pend_empty;

  // ram ports
  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_word, rd_word;

  // decode results
  logic                  accept;
  logic                  push_ok, go_read;
  deq_pkg::status_t      res_status;
  logic [deq_pkg::DATA_W-1:0] res_data;

  // port word to store width: zero extension, or truncation to the store width
  logic [EXT_W-1:0] value_ext;
  logic [EXT_W-1:0] rd_ext;
  logic [EXT_W-1:0] ones_ext;

  assign value_ext = EXT_W'($unsigned(cmd.value));
  assign wr_word   = value_ext[DATA_WIDTH-1:0];
  assign rd_ext    = EXT_W'(rd_word);
  assign ones_ext  = EXT_W'({DATA_WIDTH{1'b1}});

  // take a new word only when idle and the output register will be free
  assign cmd.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
    slot_next = (i == LAST_SLOT) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
    slot_prev = (i == '0) ? LAST_SLOT : i - 1'b1;
  endfunction

  // operation decode and index update
  always_comb begin
    front_next = front;
    rear_next  = rear;
    count_next = count;
    push_ok    = 1'b0;
    go_read    = 1'b0;
    wr_addr    = front;
    rd_addr    = rear;
    res_status = deq_pkg::ST_OK;
    res_data   = '0;
    unique case (deq_pkg::func_t'(cmd.func))
      deq_pkg::FN_PUSH_REAR, deq_pkg::FN_PUSH_FRONT: begin
        if (count == FULL_CNT) begin
          res_status = deq_pkg::ST_OVERFLOW;
        end else if (deq_pkg::func_t'(cmd.func) == deq_pkg::FN_PUSH_REAR) begin
          push_ok    = 1'b1;
          rear_next  = slot_prev(rear);
          wr_addr    = slot_prev(rear);
          count_next = count + 1'b1;
        end else begin
          push_ok    = 1'b1;
          wr_addr    = front;
          front_next = slot_next(front);
          count_next = count + 1'b1;
        end
      end
      deq_pkg::FN_POP_REAR, deq_pkg::FN_POP_FRONT,
      deq_pkg::FN_PEEK_REAR, deq_pkg::FN_PEEK_FRONT: begin
        if (count == '0) begin
          res_status = deq_pkg::ST_UNDERFLOW;
          res_data   = ones_ext[deq_pkg::DATA_W-1:0];
        end else begin
          go_read = 1'b1;
          unique case (deq_pkg::func_t'(cmd.func))
            deq_pkg::FN_POP_REAR: begin
              rd_addr    = rear;
              rear_next  = slot_next(rear);
              count_next = count - 1'b1;
            end
            deq_pkg::FN_POP_FRONT: begin
              rd_addr    = slot_prev(front);
              front_next = slot_prev(front);
              count_next = count - 1'b1;
            end
            deq_pkg::FN_PEEK_REAR: begin
              rd_addr = rear;
            end
            default: begin
              rd_addr = slot_prev(front);
            end
          endcase
        end
      end
      default: begin
        // emptiness query and unused codes change nothing
      end
    endcase
  end

  assign wr_en = accept && push_ok;
  assign rd_en = accept && go_read;

  // a read is never issued in the same cycle as a write, so no forwarding
  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // output valid: held until taken, set by a finished read or a direct result
  always_comb begin
    out_valid_next = out_valid && !rsp.ready;
    if (state == S_READ) begin
      // output register is known free here
      out_valid_next = 1'b1;
    end else if (accept && !go_read) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      rear      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            front <= front_next;
            rear  <= rear_next;
            count <= count_next;
            if (go_read) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      out_data   <= $signed(rd_ext[deq_pkg::DATA_W-1:0]);
      out_status <= deq_pkg::ST_OK;
      out_empty  <= pend_empty;
    end else if (accept) begin
      pend_empty <= (count_next == '0);
      if (!go_read) begin
        out_data   <= $signed(res_data);
        out_status <= res_status;
        out_empty  <= (count_next == '0);
      end
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.data     = out_data;
  assign rsp.status   = out_status;
  assign rsp.is_empty = out_empty;

endmodule

`default_nettype wire

// ===== hw/rtl/deq_checker.sv =====
// port-level checks on the deque result channel, bound to the top level
// depends on deq_pkg and double_ended_queue_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_unit_defines.svh"

module deq_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [deq_pkg::DATA_W-1:0]  out_data,
  input wire logic [deq_pkg::STATUS_W-1:0]       out_status,
  input wire logic                               out_empty
);

  // whole result payload in one vector
  logic [deq_pkg::DATA_W+deq_pkg::STATUS_W:0] out_word;

  assign out_word = {out_data, out_status, out_empty};

  // a stalled result word holds
  `DEQ_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // underflow only happens on an empty deque, which stays empty
  `DEQ_ASSERT_IMPL(a_underflow_empty, out_valid && (out_status == deq_pkg::ST_UNDERFLOW), out_empty)

  // overflow only on a full deque, never empty
  `DEQ_ASSERT_IMPL(a_overflow_full, out_valid && (out_status == deq_pkg::ST_OVERFLOW), !out_empty)

  // a refused push returns zero data
  `DEQ_ASSERT_IMPL(a_overflow_data, out_valid && (out_status == deq_pkg::ST_OVERFLOW), out_data == '0)

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_data   (rsp.data),
  .out_status (rsp.status),
  .out_empty  (rsp.is_empty)
);

`default_nettype wire
